// File: rtl/erd_pkg.sv
// erd_pkg: shared types, byte codes and helper functions of the escaped reply deframer
// used by erd_front, erd_fifo, erd_back and escaped_reply_deframer_top
`timescale 1ns / 1ps

package erd_pkg;

   // byte codes
   localparam logic [7:0] LEADER_BYTE = 8'h23;
   localparam logic [7:0] SPACE_BYTE  = 8'h20;
   localparam logic [7:0] ESCAPE_BYTE = 8'h28;
   localparam logic [7:0] CR_BYTE     = 8'h0D;
   localparam logic [7:0] XON_BYTE    = 8'h11;
   localparam logic [7:0] XOFF_BYTE   = 8'h13;
   localparam logic [7:0] LF_BYTE     = 8'h0A;
   localparam logic [7:0] ESC_CODE_MAX = 8'h04;

   // frame check values
   localparam logic [3:0] TOKEN_FIRST  = 4'd1;
   localparam logic [3:0] TOKEN_MAX    = 4'd15;
   localparam logic [3:0] TOKEN_BF_LO  = 4'd10;
   localparam logic [3:0] TOKEN_BF_HI  = 4'd11;
   localparam logic [7:0] LEN_START    = 8'd1;
   localparam logic [7:0] LEN_TOKEN10  = 8'd46;
   localparam logic [7:0] LEN_TOKEN11  = 8'd55;
   localparam logic [7:0] LEN_SPACE    = 8'd1;
   localparam logic [7:0] LEN_DATA     = 8'd2;
   localparam logic [7:0] LEN_BF_DATA  = 8'd8;

   // result kinds
   localparam logic KIND_DATA      = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   // frame status codes
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_BAD_LEADER  = 2'd1;
   localparam logic [1:0] ST_TOKEN_COUNT = 2'd2;
   localparam logic [1:0] ST_LENGTH      = 2'd3;

   // results per input byte and queue between front and back
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [3:0] token_index;
      logic       bit_field;
      logic [1:0] status;
   } result_type;

   // all results caused by one input byte, entry 0 first
   typedef struct packed {
      logic [1:0]                       count;
      result_type [MAX_RESULTS-1:0]     res;
   } bundle_type;

   // escape code to byte
   function automatic logic [7:0] unescape(input logic [2:0] code);
      logic [7:0] b;
      case (code)
         3'd0: b = CR_BYTE;
         3'd1: b = XON_BYTE;
         3'd2: b = XOFF_BYTE;
         3'd3: b = LF_BYTE;
         default: b = SPACE_BYTE;
      endcase
      return b;
   endfunction

   // status of a closing frame
   function automatic logic [1:0] frame_status(input logic [3:0] tok, input logic [7:0] len);
      logic [1:0] st;
      if (tok != TOKEN_BF_LO && tok != TOKEN_BF_HI) begin
         st = ST_TOKEN_COUNT;
      end else if (tok == TOKEN_BF_LO && len != LEN_TOKEN10) begin
         st = ST_LENGTH;
      end else if (tok == TOKEN_BF_HI && len != LEN_TOKEN11) begin
         st = ST_LENGTH;
      end else begin
         st = ST_OK;
      end
      return st;
   endfunction

endpackage

// File: rtl/escaped_reply_deframer_top.sv
// escaped_reply_deframer_top: top level of the escaped reply deframer
// depends on erd_pkg, erd_front, erd_fifo and erd_back
//
//   channel   direction  handshake          payload
//   req_      in         req_push/req_full  rx_byte, buffer_end
//   rsp_      out        rsp_pop/rsp_empty  kind, data_byte, token_index, bit_field,
//                                            status, last
//
// a byte is decoded in the cycle of its transfer; its results, none up to three, enter a
// two-bundle queue and leave one per cycle from the back while rsp_pop is held, through the
// single result port, the results of a bundle leaving in entry order, entry 0 first.
// reset is synchronous and empties the queue; frame state goes back to waiting for a leader.
// req_full rises only when the bundle queue is full; input and output stall on their own.
`timescale 1ns / 1ps

module escaped_reply_deframer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   input  logic       req_buffer_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [3:0] rsp_token_index,
   output logic       rsp_bit_field,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);
   import erd_pkg::*;

   bundle_type push_bundle;
   bundle_type pop_bundle;
   logic       q_push;
   logic       q_full;
   logic       q_pop;
   logic       q_empty;

   // byte decode and frame state
   erd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_rx_byte    (req_rx_byte),
      .req_buffer_end (req_buffer_end),
      .q_push         (q_push),
      .q_bundle       (push_bundle),
      .q_full         (q_full)
   );

   // bundle queue
   erd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_bundle),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_bundle),
      .empty     (q_empty)
   );

   // result serializer
   erd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_pop           (q_pop),
      .q_bundle        (pop_bundle),
      .q_empty         (q_empty),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_token_index (rsp_token_index),
      .rsp_bit_field   (rsp_bit_field),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule

// File: rtl/erd_front.sv
// erd_front: takes input bytes, tracks frame state and builds the result bundle of each byte
// depends on erd_pkg
`timescale 1ns / 1ps

module erd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_buffer_end,
   output logic               q_push,
   output erd_pkg::bundle_type q_bundle,
   input  logic               q_full
);
   import erd_pkg::*;

   localparam logic [1:0] PH_WAIT    = 2'd0;
   localparam logic [1:0] PH_FRAME   = 2'd1;
   localparam logic [1:0] PH_ESC     = 2'd2;
   localparam logic [1:0] PH_DISCARD = 2'd3;

   logic [1:0] phase_ff, phase_in;
   logic [3:0] token_ff, token_in;
   logic [7:0] length_ff, length_in;
   logic       accept;
   logic [1:0] n;
   logic       close;
   logic       bf;
   logic       do_frame;
   result_type [MAX_RESULTS-1:0] res;

   function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] k);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, k};
      return s[8] ? 8'hFF : s[7:0];
   endfunction

   function automatic result_type data_result(input logic [7:0] b, input logic [3:0] tok,
                                              input logic f);
      result_type r;
      r.kind        = KIND_DATA;
      r.data_byte   = b;
      r.token_index = tok;
      r.bit_field   = f;
      r.status      = ST_OK;
      return r;
   endfunction

   function automatic result_type end_result(input logic [3:0] tok, input logic [1:0] st);
      result_type r;
      r.kind        = KIND_FRAME_END;
      r.data_byte   = 8'h00;
      r.token_index = tok;
      r.bit_field   = 1'b0;
      r.status      = st;
      return r;
   endfunction

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // decode one byte into up to three results and the next frame state
   always_comb begin
      phase_in  = phase_ff;
      token_in  = token_ff;
      length_in = length_ff;
      n         = 2'd0;
      close     = 1'b0;
      res       = '0;
      bf        = 1'b0;
      do_frame  = 1'b0;
      case (phase_ff)
         PH_WAIT: begin
            if (req_rx_byte == LEADER_BYTE) begin
               token_in  = TOKEN_FIRST;
               length_in = LEN_START;
               phase_in  = PH_FRAME;
               close     = req_buffer_end;
            end else begin
               res[0]   = end_result(TOKEN_FIRST, ST_BAD_LEADER);
               n        = 2'd1;
               phase_in = (req_rx_byte == CR_BYTE || req_buffer_end) ? PH_WAIT : PH_DISCARD;
            end
         end
         PH_FRAME: begin
            do_frame = 1'b1;
            close    = req_buffer_end;
         end
         PH_ESC: begin
            phase_in  = PH_FRAME;
            bf        = (token_in == TOKEN_BF_LO || token_in == TOKEN_BF_HI);
            length_in = sat_add(length_in, bf ? LEN_BF_DATA : LEN_DATA);
            if (req_rx_byte <= ESC_CODE_MAX) begin
               res[0] = data_result(unescape(req_rx_byte[2:0]), token_in, bf);
            end else begin
               res[0]   = data_result(ESCAPE_BYTE, token_in, bf);
               do_frame = 1'b1;
            end
            n     = 2'd1;
            close = req_buffer_end;
         end
         default: begin
            if (req_rx_byte == CR_BYTE || req_buffer_end) begin
               phase_in = PH_WAIT;
            end
         end
      endcase

      // ordinary byte inside a frame
      if (do_frame) begin
         if (req_rx_byte == SPACE_BYTE) begin
            if (token_in < TOKEN_MAX) begin
               token_in = token_in + 4'd1;
            end
            length_in = sat_add(length_in, LEN_SPACE);
         end else if (req_rx_byte == ESCAPE_BYTE) begin
            phase_in = PH_ESC;
         end else if (req_rx_byte == CR_BYTE) begin
            close = 1'b1;
         end else begin
            bf        = (token_in == TOKEN_BF_LO || token_in == TOKEN_BF_HI);
            length_in = sat_add(length_in, bf ? LEN_BF_DATA : LEN_DATA);
            res[n]    = data_result(req_rx_byte, token_in, bf);
            n         = n + 2'd1;
         end
      end

      // frame close, flushing a pending escape as a literal
      if (close) begin
         if (phase_in == PH_ESC) begin
            bf        = (token_in == TOKEN_BF_LO || token_in == TOKEN_BF_HI);
            length_in = sat_add(length_in, bf ? LEN_BF_DATA : LEN_DATA);
            res[n]    = data_result(ESCAPE_BYTE, token_in, bf);
            n         = n + 2'd1;
         end
         res[n]   = end_result(token_in, frame_status(token_in, length_in));
         n        = n + 2'd1;
         phase_in = PH_WAIT;
      end
   end

   assign q_push         = accept && (n != 2'd0);
   assign q_bundle.count = n;
   assign q_bundle.res   = res;

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         token_ff  <= TOKEN_FIRST;
         length_ff <= LEN_START;
      end else if (accept) begin
         phase_ff  <= phase_in;
         token_ff  <= token_in;
         length_ff <= length_in;
      end
   end

endmodule

// File: rtl/erd_fifo.sv
// erd_fifo: short register queue of result bundles between front and back
// depends on erd_pkg
`timescale 1ns / 1ps

module erd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  erd_pkg::bundle_type push_data,
   output logic                full,
   input  logic                pop,
   output erd_pkg::bundle_type pop_data,
   output logic                empty
);
   import erd_pkg::*;

   bundle_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]     count_ff;
   logic                       do_push;
   logic                       do_pop;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QUEUE_CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QUEUE_CNT_W'(1);
         end
      end
   end

endmodule

// File: rtl/erd_back.sv
// erd_back: unpacks result bundles into single results on the output queue ports
// depends on erd_pkg
`timescale 1ns / 1ps

module erd_back (
   input  logic                clock,
   input  logic                reset,
   output logic                q_pop,
   input  erd_pkg::bundle_type q_bundle,
   input  logic                q_empty,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic                rsp_kind,
   output logic [7:0]          rsp_data_byte,
   output logic [3:0]          rsp_token_index,
   output logic                rsp_bit_field,
   output logic [1:0]          rsp_status,
   output logic                rsp_last
);
   import erd_pkg::*;

   bundle_type cur_ff;
   logic [1:0] idx_ff;
   logic       busy_ff;
   logic       take;
   logic       at_last;
   logic       load;
   result_type sel;

   assign at_last = (idx_ff == cur_ff.count - 2'd1);
   assign take    = rsp_pop && busy_ff;
   assign load    = !busy_ff || (take && at_last);
   assign q_pop   = load && !q_empty;

   // current bundle and position in it
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else if (q_pop) begin
         busy_ff <= 1'b1;
         idx_ff  <= 2'd0;
      end else if (load) begin
         busy_ff <= 1'b0;
      end else if (take) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   // result ports
   assign sel             = cur_ff.res[idx_ff];
   assign rsp_empty       = !busy_ff;
   assign rsp_kind        = sel.kind;
   assign rsp_data_byte   = sel.data_byte;
   assign rsp_token_index = sel.token_index;
   assign rsp_bit_field   = sel.bit_field;
   assign rsp_status      = sel.status;
   assign rsp_last        = at_last;

endmodule
